// ===== design/pga_pkg.sv =====
`timescale 1ns / 1ps

package pga_pkg;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int SLOT_W    = 10;
    localparam int IN_POS_W  = 32;
    localparam int MASS_W    = 16;
    localparam int GS_W      = 32;
    localparam int COUNT_W   = 11;
    localparam int ACC_W     = 48;
    localparam int TERM_W    = ACC_W + 1;
    localparam int Q_W       = 48;
    localparam int NUM_SHIFT = 24;
    localparam int CFG_ADDR_W = 1;

    // command codes
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_BODY_COUNT    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRAVITY_SCALE = 1'b1;

    // result kinds
    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic                     sat_i;
        logic                     sat_j;
        logic signed [TERM_W-1:0] tx_i;
        logic signed [TERM_W-1:0] ty_i;
        logic signed [TERM_W-1:0] tx_j;
        logic signed [TERM_W-1:0] ty_j;
    } pair_terms_t;

    typedef struct packed {
        logic                    mark;
        logic signed [ACC_W-1:0] ay;
        logic signed [ACC_W-1:0] ax;
    } acc_word_t;

    typedef struct packed {
        logic                    ovf;
        logic signed [ACC_W-1:0] val;
    } sat_sum_t;

    // accumulator add clamped to the 48-bit signed range
    function automatic sat_sum_t sat_add(input logic signed [ACC_W-1:0] acc,
                                         input logic signed [TERM_W-1:0] term);
        logic signed [ACC_W+1:0] s;
        sat_sum_t r;
        s = (ACC_W+2)'(acc) + (ACC_W+2)'(term);
        if (s > (ACC_W+2)'(ACC_MAX)) begin
            r.ovf = 1'b1;
            r.val = ACC_MAX;
        end else if (s < (ACC_W+2)'(ACC_MIN)) begin
            r.ovf = 1'b1;
            r.val = ACC_MIN;
        end else begin
            r.ovf = 1'b0;
            r.val = s[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/pga_pair_calc.sv =====
`timescale 1ns / 1ps

module pga_pair_calc #(
    parameter int POS_W = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [POS_W-1:0]     xi,
    input  logic signed [POS_W-1:0]     yi,
    input  logic [pga_pkg::MASS_W-1:0]  mi,
    input  logic signed [POS_W-1:0]     xj,
    input  logic signed [POS_W-1:0]     yj,
    input  logic [pga_pkg::MASS_W-1:0]  mj,
    input  logic [pga_pkg::GS_W-1:0]    gscale,
    output logic                        done,
    output pga_pkg::pair_terms_t        terms
);
    import pga_pkg::*;

    localparam int D_W    = POS_W + 1;
    localparam int MAG_W  = POS_W + 1;
    localparam int ROOT_W = MAG_W;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int R3_W   = 3 * ROOT_W;
    localparam int GM_W   = GS_W + MASS_W;
    localparam int NP_W   = GM_W + MAG_W;
    localparam int P_W    = (R3_W > NP_W) ? R3_W : NP_W;
    localparam int DV_A   = R3_W + Q_W - 1;
    localparam int DV_B   = P_W + NUM_SHIFT;
    localparam int DV_W   = (DV_A > DV_B) ? DV_A : DV_B;
    localparam int BIT_W  = $clog2(Q_W);

    typedef enum logic [2:0] {
        C_IDLE, C_SQX, C_SQY, C_SQRT, C_RR, C_R3, C_NUM, C_DIV
    } calc_state_t;

    calc_state_t       state_reg;
    logic              dx_neg_reg, dy_neg_reg;
    logic [MAG_W-1:0]  magx_reg, magy_reg;
    logic [GM_W-1:0]   gm_i_reg, gm_j_reg;
    logic [SQ_W-1:0]   sq_op_reg, sq_res_reg, sq_one_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [P_W-1:0]    mul_a_reg, mul_p_reg;
    logic [MAG_W-1:0]  mul_b_reg;
    logic [R3_W-1:0]   r3_reg;
    logic [DV_W-1:0]   rem_reg, ds_reg;
    logic [Q_W-1:0]    q_reg;
    logic [BIT_W-1:0]  bit_cnt_reg;
    logic [1:0]        k_reg;
    logic              done_reg;
    pair_terms_t       terms_reg;

    logic signed [D_W-1:0]    dx_full, dy_full;
    logic [MAG_W-1:0]         magx_c, magy_c;
    logic [P_W-1:0]           mul_sum;
    logic [SQ_W-1:0]          sq_trial;
    logic                     div_fit, div_sat, div_last, term_neg;
    logic [Q_W-1:0]           q_after;
    logic signed [TERM_W-1:0] term_mag, term_val;
    logic [1:0]               k_next;

    // offsets and magnitudes of the pair
    assign dx_full = D_W'(xj) - D_W'(xi);
    assign dy_full = D_W'(yj) - D_W'(yi);
    assign magx_c  = MAG_W'(dx_full[D_W-1] ? -dx_full : dx_full);
    assign magy_c  = MAG_W'(dy_full[D_W-1] ? -dy_full : dy_full);

    // shift-add multiplier step and square root trial
    assign mul_sum  = mul_p_reg + (mul_b_reg[0] ? mul_a_reg : '0);
    assign sq_trial = sq_res_reg + sq_one_reg;

    // restoring division step, top quotient bit means clamp
    assign div_fit  = (ds_reg <= rem_reg);
    assign div_sat  = div_fit && (bit_cnt_reg == BIT_W'(Q_W - 1));
    assign div_last = div_sat || (bit_cnt_reg == '0);
    assign q_after  = div_fit ? (q_reg | (Q_W'(1) << bit_cnt_reg)) : q_reg;
    assign k_next   = k_reg + 2'd1;

    always_comb begin
        unique case (k_reg)
            2'd0: term_neg = dx_neg_reg;
            2'd1: term_neg = dy_neg_reg;
            2'd2: term_neg = !dx_neg_reg;
            default: term_neg = !dy_neg_reg;
        endcase
    end

    assign term_mag = {1'b0, q_after};
    assign term_val = term_neg ? -term_mag : term_mag;

    // sequencer: squares, root, cube, then four numerators and divisions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        dx_neg_reg <= dx_full[D_W-1];
                        dy_neg_reg <= dy_full[D_W-1];
                        magx_reg   <= magx_c;
                        magy_reg   <= magy_c;
                        gm_i_reg   <= GM_W'(gscale) * GM_W'(mi);
                        gm_j_reg   <= GM_W'(gscale) * GM_W'(mj);
                        if (magx_c == '0 && magy_c == '0) begin
                            terms_reg <= '0;
                            done_reg  <= 1'b1;
                        end else begin
                            done_reg  <= 1'b0;
                            mul_a_reg <= P_W'(magx_c);
                            mul_b_reg <= magx_c;
                            mul_p_reg <= '0;
                            state_reg <= C_SQX;
                        end
                    end else begin
                        done_reg <= 1'b0;
                    end
                end
                C_SQX: begin
                    if (mul_b_reg == '0) begin
                        mul_a_reg <= P_W'(magy_reg);
                        mul_b_reg <= magy_reg;
                        state_reg <= C_SQY;
                    end else begin
                        mul_p_reg <= mul_sum;
                        mul_a_reg <= mul_a_reg << 1;
                        mul_b_reg <= mul_b_reg >> 1;
                    end
                end
                C_SQY: begin
                    if (mul_b_reg == '0) begin
                        sq_op_reg  <= SQ_W'(mul_p_reg);
                        sq_res_reg <= '0;
                        sq_one_reg <= SQ_W'(1) << (SQ_W - 2);
                        state_reg  <= C_SQRT;
                    end else begin
                        mul_p_reg <= mul_sum;
                        mul_a_reg <= mul_a_reg << 1;
                        mul_b_reg <= mul_b_reg >> 1;
                    end
                end
                C_SQRT: begin
                    if (sq_one_reg == '0) begin
                        root_reg  <= ROOT_W'(sq_res_reg);
                        mul_a_reg <= P_W'(sq_res_reg);
                        mul_b_reg <= MAG_W'(sq_res_reg);
                        mul_p_reg <= '0;
                        state_reg <= C_RR;
                    end else begin
                        if (sq_op_reg >= sq_trial) begin
                            sq_op_reg  <= sq_op_reg - sq_trial;
                            sq_res_reg <= (sq_res_reg >> 1) + sq_one_reg;
                        end else begin
                            sq_res_reg <= sq_res_reg >> 1;
                        end
                        sq_one_reg <= sq_one_reg >> 2;
                    end
                end
                C_RR: begin
                    if (mul_b_reg == '0) begin
                        mul_a_reg <= mul_p_reg;
                        mul_b_reg <= MAG_W'(root_reg);
                        mul_p_reg <= '0;
                        state_reg <= C_R3;
                    end else begin
                        mul_p_reg <= mul_sum;
                        mul_a_reg <= mul_a_reg << 1;
                        mul_b_reg <= mul_b_reg >> 1;
                    end
                end
                C_R3: begin
                    if (mul_b_reg == '0) begin
                        r3_reg    <= R3_W'(mul_p_reg);
                        k_reg     <= 2'd0;
                        mul_a_reg <= P_W'(gm_j_reg);
                        mul_b_reg <= magx_reg;
                        mul_p_reg <= '0;
                        state_reg <= C_NUM;
                    end else begin
                        mul_p_reg <= mul_sum;
                        mul_a_reg <= mul_a_reg << 1;
                        mul_b_reg <= mul_b_reg >> 1;
                    end
                end
                C_NUM: begin
                    if (mul_b_reg == '0) begin
                        rem_reg     <= DV_W'(mul_p_reg) << NUM_SHIFT;
                        ds_reg      <= DV_W'(r3_reg) << (Q_W - 1);
                        q_reg       <= '0;
                        bit_cnt_reg <= BIT_W'(Q_W - 1);
                        state_reg   <= C_DIV;
                    end else begin
                        mul_p_reg <= mul_sum;
                        mul_a_reg <= mul_a_reg << 1;
                        mul_b_reg <= mul_b_reg >> 1;
                    end
                end
                C_DIV: begin
                    if (div_fit) begin
                        rem_reg <= rem_reg - ds_reg;
                    end
                    q_reg       <= q_after;
                    ds_reg      <= ds_reg >> 1;
                    bit_cnt_reg <= bit_cnt_reg - BIT_W'(1);
                    if (div_last) begin
                        unique case (k_reg)
                            2'd0: terms_reg.tx_i <= term_val;
                            2'd1: terms_reg.ty_i <= term_val;
                            2'd2: terms_reg.tx_j <= term_val;
                            default: terms_reg.ty_j <= term_val;
                        endcase
                        if (k_reg == 2'd0) begin
                            terms_reg.sat_i <= div_sat;
                        end else if (k_reg == 2'd1) begin
                            terms_reg.sat_i <= terms_reg.sat_i | div_sat;
                        end else if (k_reg == 2'd2) begin
                            terms_reg.sat_j <= div_sat;
                        end else begin
                            terms_reg.sat_j <= terms_reg.sat_j | div_sat;
                        end
                        if (k_reg == 2'd3) begin
                            done_reg  <= 1'b1;
                            state_reg <= C_IDLE;
                        end else begin
                            k_reg     <= k_next;
                            mul_a_reg <= P_W'(k_next[1] ? gm_i_reg : gm_j_reg);
                            mul_b_reg <= k_next[0] ? magy_reg : magx_reg;
                            mul_p_reg <= '0;
                            state_reg <= C_NUM;
                        end
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign terms = terms_reg;

endmodule

// ===== design/pairwise_gravity_accumulator_top.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// s_        in         s_tvalid / s_tready   tuser op, tdata body fields
// m_        out        m_tvalid / m_tready   tuser result kind, tdata accel fields
// cfg_      in         cfg_valid / cfg_ready cfg_addr register, cfg_data value
//
// load is written as it is accepted, read passes through T_READ into T_RESULT plus output wait
// compute: a clearing pass over all MAX_BODIES entries, then n(n-1)/2 pairs, each
//   paced by the shift-add multiplier and the 48-step divider in pga_pair_calc
// after reset a clearing pass over all MAX_BODIES entries runs with s_tready low
// a waiting result in the output register holds back only compute and read commands

module pairwise_gravity_accumulator_top #(
    parameter int MAX_BODIES = 1024,
    parameter int POS_WIDTH  = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // body_index[9:0], pos_x[41:10], pos_y[73:42], body_mass[89:74]
    input  logic [95:0]  s_tdata,
    // op[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // accel_x[47:0], accel_y[95:48], saturated[96]
    output logic [103:0] m_tdata,
    // result_kind[0]
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [pga_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]  cfg_data
);
    import pga_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BODIES);
    localparam int CNT_W  = $clog2(MAX_BODIES + 1);
    localparam int BODY_W = 2 * POS_WIDTH + MASS_W;

    typedef enum logic [3:0] {
        T_CLEAR, T_IDLE, T_READ, T_RESULT, T_RD_I, T_RD_J, T_START, T_CALC,
        T_ACI_RD, T_ACI_WR, T_ACJ_RD, T_ACJ_WR, T_NEXT
    } top_state_t;

    top_state_t                   state_reg;
    logic [COUNT_W-1:0]           count_reg;
    logic [GS_W-1:0]              gscale_reg;
    logic [CNT_W-1:0]             n_reg, i_reg, j_reg, clr_cnt_reg;
    logic                         compute_reg, any_sat_reg, slot_ok_reg;
    logic signed [POS_WIDTH-1:0]  bi_x_reg, bi_y_reg;
    logic [MASS_W-1:0]            bi_m_reg;
    logic                         res_kind_reg, res_sat_reg;
    logic signed [ACC_W-1:0]      res_x_reg, res_y_reg;
    logic                         m_tvalid_reg, m_kind_reg, m_sat_reg;
    logic signed [ACC_W-1:0]      m_ax_reg, m_ay_reg;

    // memories
    logic [BODY_W-1:0] body_mem [MAX_BODIES];
    acc_word_t         acc_mem  [MAX_BODIES];
    logic [BODY_W-1:0] body_rd_reg;
    acc_word_t         acc_rd_reg;

    // input fields
    logic [SLOT_W-1:0]            in_slot;
    logic signed [IN_POS_W-1:0]   in_x, in_y;
    logic [MASS_W-1:0]            in_mass;
    logic [31:0]                  slot_ext;
    logic                         slot_ok, s_accept, out_free;
    logic [CNT_W-1:0]             n_c;

    logic                         body_we;
    logic [IDX_W-1:0]             body_raddr, acc_raddr, acc_waddr;
    logic                         acc_we;
    acc_word_t                    acc_wdata, acc_upd;
    sat_sum_t                     sum_x, sum_y;
    logic signed [TERM_W-1:0]     term_x, term_y;
    logic                         term_sat;

    logic                         calc_start, calc_done;
    pair_terms_t                  terms;
    logic signed [POS_WIDTH-1:0]  bj_x, bj_y;
    logic [MASS_W-1:0]            bj_m;

    assign in_slot  = s_tdata[9:0];
    assign in_x     = s_tdata[41:10];
    assign in_y     = s_tdata[73:42];
    assign in_mass  = s_tdata[89:74];
    assign slot_ext = 32'(in_slot);
    assign slot_ok  = slot_ext < 32'(MAX_BODIES);
    assign s_tready = (state_reg == T_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // body count limited to the table size
    assign n_c = (32'(count_reg) > 32'(MAX_BODIES)) ? CNT_W'(MAX_BODIES)
                                                     : CNT_W'(count_reg);

    // body table port
    assign body_we    = s_accept && (s_tuser == OP_LOAD) && slot_ok;
    assign body_raddr = (state_reg == T_RD_I) ? i_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (body_we) begin
            body_mem[slot_ext[IDX_W-1:0]] <= {in_mass, POS_WIDTH'(in_y), POS_WIDTH'(in_x)};
        end
        body_rd_reg <= body_mem[body_raddr];
    end

    assign bj_x = body_rd_reg[POS_WIDTH-1:0];
    assign bj_y = body_rd_reg[2*POS_WIDTH-1:POS_WIDTH];
    assign bj_m = body_rd_reg[BODY_W-1:2*POS_WIDTH];

    // pair arithmetic
    assign calc_start = (state_reg == T_START);

    pga_pair_calc #(.POS_W(POS_WIDTH)) u_calc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (calc_start),
        .xi      (bi_x_reg),
        .yi      (bi_y_reg),
        .mi      (bi_m_reg),
        .xj      (bj_x),
        .yj      (bj_y),
        .mj      (bj_m),
        .gscale  (gscale_reg),
        .done    (calc_done),
        .terms   (terms)
    );

    // read-modify-write of one accumulator entry
    assign term_x   = (state_reg == T_ACJ_WR) ? terms.tx_j : terms.tx_i;
    assign term_y   = (state_reg == T_ACJ_WR) ? terms.ty_j : terms.ty_i;
    assign term_sat = (state_reg == T_ACJ_WR) ? terms.sat_j : terms.sat_i;
    assign sum_x    = sat_add(acc_rd_reg.ax, term_x);
    assign sum_y    = sat_add(acc_rd_reg.ay, term_y);

    always_comb begin
        acc_upd.ax   = sum_x.val;
        acc_upd.ay   = sum_y.val;
        acc_upd.mark = acc_rd_reg.mark | term_sat | sum_x.ovf | sum_y.ovf;
    end

    always_comb begin
        acc_we    = 1'b0;
        acc_waddr = i_reg[IDX_W-1:0];
        acc_wdata = acc_upd;
        acc_raddr = j_reg[IDX_W-1:0];
        priority case (state_reg)
            T_CLEAR: begin
                acc_we    = 1'b1;
                acc_waddr = clr_cnt_reg[IDX_W-1:0];
                acc_wdata = '0;
            end
            T_ACI_WR: acc_we = 1'b1;
            T_ACJ_WR: begin
                acc_we    = 1'b1;
                acc_waddr = j_reg[IDX_W-1:0];
            end
            T_IDLE:   acc_raddr = slot_ext[IDX_W-1:0];
            T_ACI_RD: acc_raddr = i_reg[IDX_W-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_rd_reg <= acc_mem[acc_raddr];
    end

    // control sequencer, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_CLEAR;
            clr_cnt_reg  <= '0;
            compute_reg  <= 1'b0;
            any_sat_reg  <= 1'b0;
            count_reg    <= COUNT_W'(2);
            gscale_reg   <= GS_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_addr)
                    REG_BODY_COUNT:    count_reg  <= cfg_data[COUNT_W-1:0];
                    REG_GRAVITY_SCALE: gscale_reg <= cfg_data;
                endcase
            end

            // a taken output register empties unless a new result is loaded this cycle
            if (m_tvalid_reg && m_tready && state_reg != T_RESULT) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                T_CLEAR: begin
                    if (clr_cnt_reg == CNT_W'(MAX_BODIES - 1)) begin
                        compute_reg <= 1'b0;
                        if (!compute_reg) begin
                            state_reg <= T_IDLE;
                        end else if (n_reg >= CNT_W'(2)) begin
                            state_reg <= T_RD_I;
                        end else begin
                            res_kind_reg <= KIND_DONE;
                            res_x_reg    <= '0;
                            res_y_reg    <= '0;
                            res_sat_reg  <= 1'b0;
                            state_reg    <= T_RESULT;
                        end
                    end else begin
                        clr_cnt_reg <= clr_cnt_reg + CNT_W'(1);
                    end
                end
                T_IDLE: begin
                    if (s_tvalid) begin
                        unique case (s_tuser)
                            OP_COMPUTE: begin
                                n_reg       <= n_c;
                                i_reg       <= '0;
                                j_reg       <= CNT_W'(1);
                                clr_cnt_reg <= '0;
                                compute_reg <= 1'b1;
                                any_sat_reg <= 1'b0;
                                state_reg   <= T_CLEAR;
                            end
                            OP_READ: begin
                                slot_ok_reg <= slot_ok;
                                state_reg   <= T_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                T_READ: begin
                    res_kind_reg <= KIND_READ;
                    res_x_reg    <= slot_ok_reg ? acc_rd_reg.ax : '0;
                    res_y_reg    <= slot_ok_reg ? acc_rd_reg.ay : '0;
                    res_sat_reg  <= slot_ok_reg && acc_rd_reg.mark;
                    state_reg    <= T_RESULT;
                end
                T_RESULT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_kind_reg   <= res_kind_reg;
                        m_ax_reg     <= res_x_reg;
                        m_ay_reg     <= res_y_reg;
                        m_sat_reg    <= res_sat_reg;
                        state_reg    <= T_IDLE;
                    end
                end
                T_RD_I: state_reg <= T_RD_J;
                T_RD_J: begin
                    bi_x_reg  <= bj_x;
                    bi_y_reg  <= bj_y;
                    bi_m_reg  <= bj_m;
                    state_reg <= T_START;
                end
                T_START: state_reg <= T_CALC;
                T_CALC: begin
                    if (calc_done) begin
                        state_reg <= T_ACI_RD;
                    end
                end
                T_ACI_RD: state_reg <= T_ACI_WR;
                T_ACI_WR: begin
                    any_sat_reg <= any_sat_reg | acc_upd.mark;
                    state_reg   <= T_ACJ_RD;
                end
                T_ACJ_RD: state_reg <= T_ACJ_WR;
                T_ACJ_WR: begin
                    any_sat_reg <= any_sat_reg | acc_upd.mark;
                    state_reg   <= T_NEXT;
                end
                T_NEXT: begin
                    if ((CNT_W+1)'(j_reg) + (CNT_W+1)'(1) < (CNT_W+1)'(n_reg)) begin
                        j_reg     <= j_reg + CNT_W'(1);
                        state_reg <= T_RD_I;
                    end else if ((CNT_W+1)'(i_reg) + (CNT_W+1)'(2) < (CNT_W+1)'(n_reg)) begin
                        i_reg     <= i_reg + CNT_W'(1);
                        j_reg     <= i_reg + CNT_W'(2);
                        state_reg <= T_RD_I;
                    end else begin
                        res_kind_reg <= KIND_DONE;
                        res_x_reg    <= '0;
                        res_y_reg    <= '0;
                        res_sat_reg  <= any_sat_reg;
                        state_reg    <= T_RESULT;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {7'd0, m_sat_reg, m_ay_reg, m_ax_reg};

    // pair arithmetic finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        calc_done |-> (state_reg == T_CALC))
        else $error("pair result outside wait state");

    // visited pairs stay ordered and inside the active body count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_RD_I || state_reg == T_ACJ_WR) |->
            (i_reg < j_reg) && (j_reg < n_reg))
        else $error("pair indices out of order");

    // clearing pass stays inside the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_CLEAR) |-> (32'(clr_cnt_reg) < 32'(MAX_BODIES)))
        else $error("clear counter past table end");

    // a result is loaded only when the output register is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_RESULT && m_tvalid_reg && !m_tready) |=>
            (state_reg == T_RESULT))
        else $error("result dropped while output stalled");

endmodule
